### src/cycle_event_scheduler_macros.svh
// Assertion macros for the cycle event scheduler.
`ifndef CYCLE_EVENT_SCHEDULER_MACROS_SVH
`define CYCLE_EVENT_SCHEDULER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define CES_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// Next-cycle implication, disabled during reset.
`define CES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`else

`define CES_ASSERT_NOW(label, clk, rst, ante, cons)
`define CES_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### src/ces_pkg.sv
// Shared types and constants for the cycle event scheduler.
`timescale 1ns / 1ps

package ces_pkg;

   localparam int NUM_SLOTS   = 8;
   localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int TREE_LEAVES = 2 ** SLOT_W;
   localparam int TIME_W      = 32;
   localparam int KIND_W      = 2;
   localparam int IDX_W       = 3;
   localparam int MASK_W      = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_ARM     = 2'd0,
      KIND_DISARM  = 2'd1,
      KIND_ADVANCE = 2'd2
   } kind_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;    // latch the incoming item
      logic calc;    // distances and distance to the nearest due time
      logic finish;  // apply item, load result register
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic out_free;  // result register empty or being taken
   } status_type;

endpackage

### src/ces_ctrl.sv
// Sequencing state machine for the cycle event scheduler.
`timescale 1ns / 1ps

module ces_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ces_pkg::status_type status,
   output ces_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // hold here while the previous result still waits
            if (status.out_free) begin
               cmd.finish = 1'b1;
               req_ready  = 1'b1;
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = ST_CALC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/ces_datapath.sv
// Slot table, cycle clock, nearest-event search and result register.
`timescale 1ns / 1ps

module ces_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ces_pkg::cmd_type                   cmd,
   output ces_pkg::status_type                status,
   input  logic [ces_pkg::KIND_W-1:0]         req_kind,
   input  logic [ces_pkg::IDX_W-1:0]          req_slot,
   input  logic [ces_pkg::TIME_W-1:0]         req_due_time,
   input  logic [ces_pkg::TIME_W-1:0]         req_cycles,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ces_pkg::MASK_W-1:0]         rsp_fired_mask,
   output logic                               rsp_any_fired,
   output logic [ces_pkg::TIME_W-1:0]         rsp_now_time,
   output logic [ces_pkg::TIME_W-1:0]         rsp_cycles_left
);

   localparam int N  = ces_pkg::NUM_SLOTS;
   localparam int TW = ces_pkg::TIME_W;
   localparam int L  = ces_pkg::TREE_LEAVES;

   // Latched item
   logic [ces_pkg::KIND_W-1:0] kind_ff;
   logic [ces_pkg::IDX_W-1:0]  slot_ff;
   logic [TW-1:0]              item_due_ff;
   logic [TW-1:0]              item_cycles_ff;

   // Table and clock
   logic [N-1:0]  active_ff, active_in;
   logic [TW-1:0] slot_due_ff [N];
   logic [TW-1:0] slot_due_in [N];
   logic [TW-1:0] clock_ff, clock_in;

   // Search stage
   logic [TW-1:0] dist_ff [N];
   logic [TW-1:0] dist_in [N];
   logic [N-1:0]  cand_ff;
   logic [TW-1:0] best_ff;
   logic          found_ff;
   logic [TW:0]   node [2*L-1];

   // Result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ces_pkg::MASK_W-1:0] mask_ff, mask_in;
   logic                       any_ff, any_in;
   logic [TW-1:0]              now_ff;
   logic [TW-1:0]              left_ff, left_in;

   logic         take;
   logic         slot_ok;
   logic [N-1:0] fire;

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // Distance of every slot, then a min tree over {inactive, distance} keys.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         dist_in[i] = slot_due_ff[i] - clock_ff;
      end
      for (int i = 0; i < L; i++) begin
         if (i < N) begin
            node[L-1+i] = {!active_ff[i], dist_in[i]};
         end else begin
            node[L-1+i] = '1;
         end
      end
      for (int n = L - 2; n >= 0; n--) begin
         node[n] = (node[2*n+2] < node[2*n+1]) ? node[2*n+2] : node[2*n+1];
      end
   end

   assign take    = found_ff && (best_ff <= item_cycles_ff);
   assign slot_ok = 32'(slot_ff) < N;

   always_comb begin
      active_in = active_ff;
      clock_in  = clock_ff;
      fire      = '0;
      mask_in   = '0;
      any_in    = 1'b0;
      left_in   = '0;
      for (int i = 0; i < N; i++) begin
         slot_due_in[i] = slot_due_ff[i];
      end
      case (ces_pkg::kind_type'(kind_ff))
         ces_pkg::KIND_ARM: begin
            for (int i = 0; i < N; i++) begin
               if (slot_ok && 32'(slot_ff) == i) begin
                  active_in[i]   = 1'b1;
                  slot_due_in[i] = item_due_ff;
               end
            end
         end
         ces_pkg::KIND_DISARM: begin
            for (int i = 0; i < N; i++) begin
               if (slot_ok && 32'(slot_ff) == i) begin
                  active_in[i] = 1'b0;
               end
            end
         end
         ces_pkg::KIND_ADVANCE: begin
            if (take) begin
               for (int i = 0; i < N; i++) begin
                  fire[i] = cand_ff[i] && (dist_ff[i] == best_ff);
               end
               active_in = active_ff & ~fire;
               clock_in  = clock_ff + best_ff;
               left_in   = item_cycles_ff - best_ff;
               any_in    = 1'b1;
               for (int i = 0; i < ces_pkg::MASK_W; i++) begin
                  if (i < N) begin
                     mask_in[i] = fire[i];
                  end
               end
            end else begin
               clock_in = clock_ff + item_cycles_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < N; i++) begin
            slot_due_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.finish) begin
            active_ff <= active_in;
            clock_ff  <= clock_in;
            for (int i = 0; i < N; i++) begin
               slot_due_ff[i] <= slot_due_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff        <= req_kind;
         slot_ff        <= req_slot;
         item_due_ff    <= req_due_time;
         item_cycles_ff <= req_cycles;
      end
      if (cmd.calc) begin
         for (int i = 0; i < N; i++) begin
            dist_ff[i] <= dist_in[i];
         end
         cand_ff  <= active_ff;
         best_ff  <= node[0][TW-1:0];
         found_ff <= !node[0][TW];
      end
      if (cmd.finish) begin
         mask_ff <= mask_in;
         any_ff  <= any_in;
         now_ff  <= clock_in;
         left_ff <= left_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fired_mask  = mask_ff;
   assign rsp_any_fired   = any_ff;
   assign rsp_now_time    = now_ff;
   assign rsp_cycles_left = left_ff;

endmodule

### src/cycle_event_scheduler.sv
// Cycle event scheduler: eight one-shot event slots against a 32-bit cycle clock.
// Use: the req channel carries one item per handshake: arm a slot with an
// absolute due time, disarm a slot, or advance the clock by req_cycles.
// Every item answers with exactly one rsp item: the mask of slots that fired,
// a fired flag, the clock after the item and the cycles of the advance left
// unused when the clock stopped at the nearest armed due time.
// Each accepted item is latched, then the search step registers the slot
// distances and the min tree result, then the update step applies the item
// and loads the output register. A new item is taken only as the previous
// one is applied, so the search and update steps never hold two items at once.
// A stalled rsp side holds the result in its output register; the block
// finishes the following item only once that register is taken, and until
// then stops accepting further items.
// Reset (synchronous, active high) disarms all slots, clears the clock to 0
// and empties the output register.
`timescale 1ns / 1ps
`include "cycle_event_scheduler_macros.svh"

module cycle_event_scheduler (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ces_pkg::KIND_W-1:0] req_kind,
   input  logic [ces_pkg::IDX_W-1:0]  req_slot,
   input  logic [ces_pkg::TIME_W-1:0] req_due_time,
   input  logic [ces_pkg::TIME_W-1:0] req_cycles,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ces_pkg::MASK_W-1:0] rsp_fired_mask,
   output logic                       rsp_any_fired,
   output logic [ces_pkg::TIME_W-1:0] rsp_now_time,
   output logic [ces_pkg::TIME_W-1:0] rsp_cycles_left
);

   ces_pkg::cmd_type    cmd;
   ces_pkg::status_type status;

   ces_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ces_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_slot        (req_slot),
      .req_due_time    (req_due_time),
      .req_cycles      (req_cycles),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_fired_mask  (rsp_fired_mask),
      .rsp_any_fired   (rsp_any_fired),
      .rsp_now_time    (rsp_now_time),
      .rsp_cycles_left (rsp_cycles_left)
   );

   `CES_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `CES_ASSERT_NOW(a_finish_needs_room, clock, reset, cmd.finish, status.out_free)
   `CES_ASSERT_NOW(a_calc_not_finish, clock, reset, cmd.calc, !cmd.finish && !cmd.load)
   `CES_ASSERT_NOW(a_quiet_result, clock, reset, rsp_valid && !rsp_any_fired,
                   rsp_fired_mask == '0 && rsp_cycles_left == '0)

endmodule

### tb/ces_checker.sv
// Checker for the cycle event scheduler: tracks the slot table and clock, predicts each result.
`timescale 1ns / 1ps

module ces_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [ces_pkg::KIND_W-1:0] req_kind,
   input  logic [ces_pkg::IDX_W-1:0]  req_slot,
   input  logic [ces_pkg::TIME_W-1:0] req_due_time,
   input  logic [ces_pkg::TIME_W-1:0] req_cycles,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [ces_pkg::MASK_W-1:0] rsp_fired_mask,
   input  logic                       rsp_any_fired,
   input  logic [ces_pkg::TIME_W-1:0] rsp_now_time,
   input  logic [ces_pkg::TIME_W-1:0] rsp_cycles_left,
   output int                         fail_count,
   output int                         pending,
   output int                         fire_count,
   output logic [ces_pkg::TIME_W-1:0] clock_model
);

   typedef struct packed {
      logic [ces_pkg::MASK_W-1:0] mask;
      logic                       fired;
      logic [ces_pkg::TIME_W-1:0] now;
      logic [ces_pkg::TIME_W-1:0] spare;
   } outcome_type;

   logic                       slot_armed [ces_pkg::NUM_SLOTS];
   logic [ces_pkg::TIME_W-1:0] slot_due   [ces_pkg::NUM_SLOTS];
   logic [ces_pkg::TIME_W-1:0] clk_now;
   outcome_type                outcomes_q [$];

   task automatic report_mismatch(input string field,
                                  input logic [ces_pkg::TIME_W-1:0] got,
                                  input logic [ces_pkg::TIME_W-1:0] want);
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
      fail_count++;
   endtask

   // Apply one accepted item to the slot table and queue the result it must produce.
   task automatic advance_schedule(input logic [ces_pkg::KIND_W-1:0] kind,
                                   input logic [ces_pkg::IDX_W-1:0]  slot,
                                   input logic [ces_pkg::TIME_W-1:0] due,
                                   input logic [ces_pkg::TIME_W-1:0] cycles);
      outcome_type                o;
      logic                       found;
      logic [ces_pkg::TIME_W-1:0] best;
      logic [ces_pkg::TIME_W-1:0] gap;
      o     = '0;
      found = 1'b0;
      best  = '0;
      case (kind)
         ces_pkg::KIND_ARM: begin
            if (slot < ces_pkg::NUM_SLOTS) begin
               slot_armed[slot] = 1'b1;
               slot_due[slot]   = due;
            end
         end
         ces_pkg::KIND_DISARM: begin
            if (slot < ces_pkg::NUM_SLOTS) slot_armed[slot] = 1'b0;
         end
         ces_pkg::KIND_ADVANCE: begin
            // distances wrap modulo 2^32 from the current clock
            for (int i = 0; i < ces_pkg::NUM_SLOTS; i++) begin
               if (slot_armed[i]) begin
                  gap = slot_due[i] - clk_now;
                  if (!found || gap < best) begin
                     best  = gap;
                     found = 1'b1;
                  end
               end
            end
            if (found && best <= cycles) begin
               o.spare = cycles - best;
               clk_now = clk_now + best;
               for (int i = 0; i < ces_pkg::NUM_SLOTS; i++) begin
                  if (slot_armed[i] && slot_due[i] == clk_now) begin
                     slot_armed[i] = 1'b0;
                     if (i < ces_pkg::MASK_W) o.mask[i] = 1'b1;
                  end
               end
               o.fired = 1'b1;
               fire_count++;
            end else begin
               clk_now = clk_now + cycles;
            end
         end
         default: ;
      endcase
      o.now = clk_now;
      outcomes_q.push_back(o);
   endtask

   task automatic check_outcome();
      outcome_type w;
      if (outcomes_q.size() == 0) begin
         report_mismatch("result with none outstanding", rsp_now_time, '0);
         return;
      end
      w = outcomes_q.pop_front();
      if (rsp_fired_mask !== w.mask) report_mismatch("fired_mask", rsp_fired_mask, w.mask);
      if (rsp_any_fired !== w.fired) report_mismatch("any_fired", rsp_any_fired, w.fired);
      if (rsp_now_time !== w.now) report_mismatch("now_time", rsp_now_time, w.now);
      if (rsp_cycles_left !== w.spare) report_mismatch("cycles_left", rsp_cycles_left, w.spare);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ces_pkg::NUM_SLOTS; i++) begin
            slot_armed[i] = 1'b0;
            slot_due[i]   = '0;
         end
         clk_now = '0;
         outcomes_q.delete();
         fail_count = 0;
         fire_count = 0;
      end else begin
         // retire before predicting: a result can never belong to the item taken this edge
         if (rsp_valid && rsp_ready) check_outcome();
         if (req_valid && req_ready)
            advance_schedule(req_kind, req_slot, req_due_time, req_cycles);
      end
      pending     <= outcomes_q.size();
      clock_model <= clk_now;
   end

endmodule

### tb/tb_cycle_event_scheduler.sv
// Testbench top for the cycle event scheduler: stimulus, handshake idling, watchdog and verdict.
`timescale 1ns / 1ps

module tb_cycle_event_scheduler;

   localparam logic [ces_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 175;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [ces_pkg::KIND_W-1:0] req_kind = '0;
   logic [ces_pkg::IDX_W-1:0]  req_slot = '0;
   logic [ces_pkg::TIME_W-1:0] req_due_time = '0;
   logic [ces_pkg::TIME_W-1:0] req_cycles = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [ces_pkg::MASK_W-1:0] rsp_fired_mask;
   logic                       rsp_any_fired;
   logic [ces_pkg::TIME_W-1:0] rsp_now_time;
   logic [ces_pkg::TIME_W-1:0] rsp_cycles_left;

   int                         fail_count;
   int                         pending;
   int                         fire_count;
   logic [ces_pkg::TIME_W-1:0] clock_model;

   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int n_kind [4] = '{0, 0, 0, 0};

   always #5 clock = ~clock;

   cycle_event_scheduler dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_slot        (req_slot),
      .req_due_time    (req_due_time),
      .req_cycles      (req_cycles),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_fired_mask  (rsp_fired_mask),
      .rsp_any_fired   (rsp_any_fired),
      .rsp_now_time    (rsp_now_time),
      .rsp_cycles_left (rsp_cycles_left)
   );

   ces_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_slot        (req_slot),
      .req_due_time    (req_due_time),
      .req_cycles      (req_cycles),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_fired_mask  (rsp_fired_mask),
      .rsp_any_fired   (rsp_any_fired),
      .rsp_now_time    (rsp_now_time),
      .rsp_cycles_left (rsp_cycles_left),
      .fail_count      (fail_count),
      .pending         (pending),
      .fire_count      (fire_count),
      .clock_model     (clock_model)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog: cycles in a row with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", quiet_cycles);
         $display("FAIL cycle_event_scheduler");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called at a rising edge; returns at the edge where the item is accepted.
   task automatic send_item(input logic [ces_pkg::KIND_W-1:0] kind,
                            input logic [ces_pkg::IDX_W-1:0]  slot,
                            input logic [ces_pkg::TIME_W-1:0] due,
                            input logic [ces_pkg::TIME_W-1:0] cycles);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_slot     <= slot;
      req_due_time <= due;
      req_cycles   <= cycles;
      do @(posedge clock); while (!req_ready);
      n_kind[kind]++;
   endtask

   // Hold the sender off until every outstanding result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Mostly arms near the clock and short advances so events keep firing.
   task automatic random_item();
      logic [ces_pkg::KIND_W-1:0] k;
      logic [ces_pkg::IDX_W-1:0]  s;
      logic [ces_pkg::TIME_W-1:0] d;
      logic [ces_pkg::TIME_W-1:0] c;
      int                         pick;
      int                         r;
      s    = ces_pkg::IDX_W'($urandom);
      d    = $urandom;
      c    = $urandom;
      pick = $urandom_range(99);
      r    = $urandom_range(99);
      if (pick < 30) begin
         k = ces_pkg::KIND_ARM;
         if (r < 70) d = clock_model + $urandom_range(0, 64);
         else if (r < 85) d = clock_model - $urandom_range(1, 16);
      end else if (pick < 40) begin
         k = ces_pkg::KIND_DISARM;
      end else if (pick < 44) begin
         k = KIND_UNUSED;
      end else begin
         k = ces_pkg::KIND_ADVANCE;
         if (r < 50) c = $urandom_range(0, 80);
         else if (r < 65) c = '0;
         else if (r < 80) c = 32'hFFFF_FFFF - $urandom_range(0, 3);
      end
      send_item(k, s, d, c);
   endtask

   task automatic run_phase(input int idle, input int stall, input int target);
      drain();
      idle_pct = idle;
      stall_pct <= stall;
      while (n_kind[ces_pkg::KIND_ARM] + n_kind[ces_pkg::KIND_DISARM]
             + n_kind[ces_pkg::KIND_ADVANCE] < target)
         random_item();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty table: advances never stop, including the widest span and the wrap
      send_item(ces_pkg::KIND_ADVANCE, 3'd0, '0, '0);
      send_item(ces_pkg::KIND_ADVANCE, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(ces_pkg::KIND_ADVANCE, 3'd0, '0, 32'd1);
      // two slots due together, one far away
      send_item(ces_pkg::KIND_ARM, 3'd0, 32'd5, '0);
      send_item(ces_pkg::KIND_ARM, 3'd7, 32'd5, 32'hFFFF_FFFF);
      send_item(ces_pkg::KIND_ARM, 3'd3, 32'hFFFF_FFFF, '0);
      send_item(ces_pkg::KIND_ADVANCE, 3'd0, '0, 32'd3);
      send_item(ces_pkg::KIND_ADVANCE, 3'd0, '0, 32'd2);
      // zero advance fires a slot due now
      send_item(ces_pkg::KIND_ARM, 3'd1, 32'd5, '0);
      send_item(ces_pkg::KIND_ADVANCE, 3'd0, '0, '0);
      // re-arm overwrites the due time; disarmed slot must not fire
      send_item(ces_pkg::KIND_ARM, 3'd2, 32'd10, '0);
      send_item(ces_pkg::KIND_ARM, 3'd2, 32'd20, '0);
      send_item(ces_pkg::KIND_DISARM, 3'd3, '0, '0);
      send_item(ces_pkg::KIND_ADVANCE, 3'd0, '0, 32'd100);
      send_item(KIND_UNUSED, 3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // slot behind the clock is nearly a full wrap away
      send_item(ces_pkg::KIND_ARM, 3'd5, '0, '0);
      send_item(ces_pkg::KIND_ARM, 3'd6, 32'hFFFF_FFFF, '0);
      send_item(ces_pkg::KIND_ADVANCE, 3'd0, '0, 32'hFFFF_FFFF);
      send_item(ces_pkg::KIND_ADVANCE, 3'd0, '0, 32'd1);
      // every slot at once
      drain();
      for (int i = 0; i < ces_pkg::NUM_SLOTS; i++)
         send_item(ces_pkg::KIND_ARM, i[ces_pkg::IDX_W-1:0], clock_model + 7, '0);
      send_item(ces_pkg::KIND_ADVANCE, 3'd0, '0, 32'd7);

      run_phase(0, 0, PHASE_ITEMS);
      run_phase(57, 0, 2 * PHASE_ITEMS);
      run_phase(0, 57, 3 * PHASE_ITEMS);
      run_phase(33, 33, 4 * PHASE_ITEMS);

      drain();
      repeat (4) @(posedge clock);
      $display("ran %0d arm, %0d disarm, %0d advance and %0d unused-kind items",
               n_kind[ces_pkg::KIND_ARM], n_kind[ces_pkg::KIND_DISARM],
               n_kind[ces_pkg::KIND_ADVANCE], n_kind[KIND_UNUSED]);
      $display("%0d advances stopped on a due slot; %0d mismatches", fire_count, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS cycle_event_scheduler");
      end else begin
         $display("FAIL cycle_event_scheduler");
      end
      $finish;
   end

endmodule
